@@ hw/rtl/see_pkg.sv @@
// Shared types and codes for the stack expression evaluator.
// Depends on nothing; imported by the interfaces, the ALU, the top level and the testbench.
`default_nettype none
package see_pkg;

   typedef logic signed [63:0] q_type;
   typedef logic [1:0]  cmd_type;
   typedef logic [7:0]  opcode_type;
   typedef logic [7:0]  index_type;
   typedef logic [2:0]  status_type;
   typedef logic [8:0]  count_cfg_type;

   // command codes
   localparam cmd_type CMD_WRITE  = 2'd0;
   localparam cmd_type CMD_EXEC   = 2'd1;
   localparam cmd_type CMD_FINISH = 2'd2;

   // opcodes
   localparam opcode_type OP_HALT = 8'h00;
   localparam opcode_type OP_PUSH = 8'h01;
   localparam opcode_type OP_LOAD = 8'h02;
   localparam opcode_type OP_ADD  = 8'h10;
   localparam opcode_type OP_SUB  = 8'h11;
   localparam opcode_type OP_MUL  = 8'h12;
   localparam opcode_type OP_DIV  = 8'h13;
   localparam opcode_type OP_EQ   = 8'h20;
   localparam opcode_type OP_GT   = 8'h21;
   localparam opcode_type OP_LT   = 8'h22;
   localparam opcode_type OP_AND  = 8'h30;
   localparam opcode_type OP_OR   = 8'h31;
   localparam opcode_type OP_NOT  = 8'h32;

   // sticky status codes
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_HALTED    = 3'd1;
   localparam status_type ST_OVERFLOW  = 3'd2;
   localparam status_type ST_UNDERFLOW = 3'd3;
   localparam status_type ST_DIV_ZERO  = 3'd4;
   localparam status_type ST_BAD_INDEX = 3'd5;
   localparam status_type ST_BAD_OP    = 3'd6;

   localparam logic [63:0] Q_ONE   = 64'h0000_0001_0000_0000;
   localparam logic [63:0] Q_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] Q_MIN   = 64'h8000_0000_0000_0000;

   // operands of the shared 65-bit adder
   typedef struct packed {
      logic [64:0] x;
      logic [64:0] y;
      logic        sub;
   } alu_req_type;

endpackage
`default_nettype wire

@@ hw/rtl/see_req_if.sv @@
// Request channel: one command beat per item.
// Depends on see_pkg.
`default_nettype none
interface see_req_if;
   import see_pkg::*;
   logic       valid;
   logic       ready;
   cmd_type    cmd;
   opcode_type opcode;
   q_type      immediate;
   index_type  var_index;
   modport source (output valid, cmd, opcode, immediate, var_index, input ready);
   modport sink   (input valid, cmd, opcode, immediate, var_index, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/see_rsp_if.sv @@
// Response channel: one result beat per request.
// Depends on see_pkg.
`default_nettype none
interface see_rsp_if;
   import see_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   logic       done_res;
   logic       answer;
   q_type      top_value;
   modport source (output valid, status, done_res, answer, top_value, input ready);
   modport sink   (input valid, status, done_res, answer, top_value, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/see_csr_if.sv @@
// Register write channel carrying the variable count.
// Depends on see_pkg.
`default_nettype none
interface see_csr_if;
   import see_pkg::*;
   logic          valid;
   logic          ready;
   count_cfg_type data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/see_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module see_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                           wdata,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                           rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ hw/rtl/see_alu.sv @@
// Shared 65-bit add/subtract unit used by every arithmetic step.
// Depends on see_pkg.
`default_nettype none
module see_alu (
   input  wire see_pkg::alu_req_type req,
   output logic [64:0]               sum
);
   import see_pkg::*;
   always_comb begin
      sum = req.sub ? (req.x + ~req.y + 65'd1) : (req.x + req.y);
   end
endmodule
`default_nettype wire

@@ hw/rtl/stack_expression_evaluator.sv @@
// Stack expression evaluator: top level, sequencer, stack and variable RAMs.
// Depends on see_pkg, see_req_if, see_rsp_if, see_csr_if, see_ram, see_alu.
// Write, finish and simple instructions go idle, decode, response; mul and div add
// magnitude, loop (one bit a cycle) and fix states; a saturating div skips the loop.
// Throughput: one item at a time; the next request is taken after the response loads.
// Reset: synchronous, clears stack count, sticky status, variable count, handshakes.
`default_nettype none
module stack_expression_evaluator #(
   parameter int STACK_DEPTH = 256,
   parameter int VAR_DEPTH   = 256
) (
   input wire logic clock,
   input wire logic reset,
   see_req_if.sink   req_chan,
   see_rsp_if.source rsp_chan,
   see_csr_if.sink   csr_chan
);
   import see_pkg::*;

   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int AW  = STACK_DEPTH > 1 ? $clog2(STACK_DEPTH) : 1;
   localparam int VAW = VAR_DEPTH > 1 ? $clog2(VAR_DEPTH) : 1;
   localparam logic [8:0]    VarLimit  = 9'(VAR_DEPTH);
   localparam logic [CW-1:0] StackFull = CW'(STACK_DEPTH);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_MAGA   = 4'd2;
   localparam logic [3:0] S_MAGB   = 4'd3;
   localparam logic [3:0] S_MUL    = 4'd4;
   localparam logic [3:0] S_DCHK   = 4'd5;
   localparam logic [3:0] S_DIV    = 4'd6;
   localparam logic [3:0] S_FIX    = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;

   // control state
   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   status_type    sticky_ff, sticky_in;
   count_cfg_type var_count_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [5:0]    iter_ff, iter_in;

   // payload state
   cmd_type       cmd_ff;
   opcode_type    op_ff;
   logic [63:0]   imm_ff;
   index_type     idx_ff;
   logic [63:0]   top_ff, top_in;
   logic [63:0]   ua_ff, ua_in;
   logic [63:0]   ub_ff, ub_in;
   logic [63:0]   hi_ff, hi_in;
   logic [63:0]   lo_ff, lo_in;
   logic          neg_ff, neg_in;
   logic          ovf_ff, ovf_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic          rsp_done_ff, rsp_done_in;
   logic          rsp_answer_ff, rsp_answer_in;
   logic [63:0]   rsp_top_ff, rsp_top_in;

   // RAM ports
   logic          st_we;
   logic [AW-1:0] st_waddr, st_raddr;
   logic [63:0]   st_wdata, st_rdata;
   logic          var_we;
   logic [63:0]   var_rdata;

   alu_req_type   alu_req;
   logic [64:0]   alu_sum;

   logic          req_fire;
   logic [CW-1:0] count_m1, count_m2;
   logic [63:0]   a_val, bin_r, mag_m, fix_r, rem_sh;
   logic          lt_flag, sat_ovf, over_m, sat_m, quot_bit, rsp_free;

   assign req_fire     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;

   assign count_m1 = count_ff - CW'(1);
   assign count_m2 = count_ff - CW'(2);
   assign st_raddr = count_m2[AW-1:0];
   assign a_val    = st_rdata;

   see_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   // read the variable slot at the accept edge so it is ready in decode
   see_ram #(.WIDTH(64), .DEPTH(VAR_DEPTH)) u_var_ram (
      .clock (clock),
      .we    (var_we),
      .waddr (idx_ff[VAW-1:0]),
      .wdata (imm_ff),
      .raddr (req_chan.var_index[VAW-1:0]),
      .rdata (var_rdata)
   );

   see_alu u_alu (
      .req (alu_req),
      .sum (alu_sum)
   );

   // binary-op result from the decode-cycle adder (a - b, or a + b for add)
   always_comb begin
      lt_flag = alu_sum[64];
      sat_ovf = alu_sum[64] ^ alu_sum[63];
      case (op_ff) inside
         OP_ADD, OP_SUB: bin_r = sat_ovf ? (a_val[63] ? Q_MIN : Q_MAX) : alu_sum[63:0];
         OP_EQ:          bin_r = (a_val == top_ff) ? Q_ONE : 64'd0;
         OP_GT:          bin_r = (!lt_flag && a_val != top_ff) ? Q_ONE : 64'd0;
         OP_LT:          bin_r = lt_flag ? Q_ONE : 64'd0;
         OP_AND:         bin_r = (a_val != 64'd0 && top_ff != 64'd0) ? Q_ONE : 64'd0;
         default:        bin_r = (a_val != 64'd0 || top_ff != 64'd0) ? Q_ONE : 64'd0;
      endcase
   end

   // magnitude result of mul or div, then sign and saturation
   always_comb begin
      if (op_ff == OP_MUL) begin
         mag_m  = {hi_ff[31:0], lo_ff[63:32]};
         over_m = (hi_ff[63:32] != 32'd0);
      end else begin
         mag_m  = lo_ff;
         over_m = ovf_ff;
      end
      sat_m = neg_ff ? (over_m || (mag_m[63] && mag_m[62:0] != 63'd0))
                     : (over_m || mag_m[63]);
      if (sat_m) begin
         fix_r = neg_ff ? Q_MIN : Q_MAX;
      end else if (neg_ff) begin
         fix_r = alu_sum[63:0];
      end else begin
         fix_r = mag_m;
      end
   end

   assign rem_sh   = {hi_ff[62:0], lo_ff[63]};
   assign quot_bit = !alu_sum[64];
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      sticky_in     = sticky_ff;
      iter_in       = iter_ff;
      top_in        = top_ff;
      ua_in         = ua_ff;
      ub_in         = ub_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      neg_in        = neg_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_answer_in = rsp_answer_ff;
      rsp_top_in    = rsp_top_ff;
      st_we         = 1'b0;
      st_waddr      = count_m2[AW-1:0];
      st_wdata      = bin_r;
      var_we        = 1'b0;
      alu_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in    = S_RESP;
            neg_in      = a_val[63] ^ top_ff[63];
            alu_req.x   = {a_val[63], a_val};
            alu_req.y   = {top_ff[63], top_ff};
            alu_req.sub = (op_ff != OP_ADD);
            if (cmd_ff == CMD_WRITE) begin
               var_we = ({1'b0, idx_ff} < VarLimit);
            end else if (cmd_ff == CMD_EXEC && sticky_ff == ST_OK) begin
               case (op_ff) inside
                  OP_HALT: sticky_in = ST_HALTED;
                  OP_PUSH, OP_LOAD: begin
                     if (op_ff == OP_LOAD &&
                         !({1'b0, idx_ff} < var_count_ff && {1'b0, idx_ff} < VarLimit)) begin
                        sticky_in = ST_BAD_INDEX;
                     end else if (count_ff >= StackFull) begin
                        sticky_in = ST_OVERFLOW;
                     end else begin
                        st_we    = 1'b1;
                        st_waddr = count_ff[AW-1:0];
                        st_wdata = (op_ff == OP_LOAD) ? var_rdata : imm_ff;
                        top_in   = st_wdata;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_NOT: begin
                     if (count_ff == '0) begin
                        sticky_in = ST_UNDERFLOW;
                     end else begin
                        st_we    = 1'b1;
                        st_waddr = count_m1[AW-1:0];
                        st_wdata = (top_ff == 64'd0) ? Q_ONE : 64'd0;
                        top_in   = st_wdata;
                     end
                  end
                  OP_ADD, OP_SUB, OP_EQ, OP_GT, OP_LT, OP_AND, OP_OR: begin
                     if (count_ff < CW'(2)) begin
                        sticky_in = ST_UNDERFLOW;
                     end else begin
                        st_we    = 1'b1;
                        top_in   = bin_r;
                        count_in = count_m1;
                     end
                  end
                  OP_MUL, OP_DIV: begin
                     if (count_ff < CW'(2)) begin
                        sticky_in = ST_UNDERFLOW;
                     end else if (op_ff == OP_DIV && top_ff == 64'd0) begin
                        sticky_in = ST_DIV_ZERO;
                     end else begin
                        state_in = S_MAGA;
                     end
                  end
                  default: sticky_in = ST_BAD_OP;
               endcase
            end
         end
         S_MAGA: begin
            alu_req.y   = {1'b0, a_val};
            alu_req.sub = a_val[63];
            ua_in       = alu_sum[63:0];
            state_in    = S_MAGB;
         end
         S_MAGB: begin
            alu_req.y   = {1'b0, top_ff};
            alu_req.sub = top_ff[63];
            ub_in       = alu_sum[63:0];
            lo_in       = alu_sum[63:0];
            hi_in       = 64'd0;
            ovf_in      = 1'b0;
            iter_in     = 6'd63;
            state_in    = (op_ff == OP_MUL) ? S_MUL : S_DCHK;
         end
         S_MUL: begin
            // shift-add: add multiplicand on a set multiplier bit, shift right
            alu_req.x = {1'b0, hi_ff};
            alu_req.y = {1'b0, ua_ff};
            if (lo_ff[0]) begin
               hi_in = alu_sum[64:1];
               lo_in = {alu_sum[0], lo_ff[63:1]};
            end else begin
               hi_in = {1'b0, hi_ff[63:1]};
               lo_in = {hi_ff[0], lo_ff[63:1]};
            end
            iter_in = iter_ff - 6'd1;
            if (iter_ff == 6'd0) begin
               state_in = S_FIX;
            end
         end
         S_DCHK: begin
            // quotient reaches 2^64 exactly when |a| >= |b| << 32
            alu_req.x   = {1'b0, ua_ff};
            alu_req.y   = {1'b0, ub_ff[31:0], 32'd0};
            alu_req.sub = 1'b1;
            if (ub_ff[63:32] == 32'd0 && !alu_sum[64]) begin
               ovf_in   = 1'b1;
               state_in = S_FIX;
            end else begin
               hi_in    = {32'd0, ua_ff[63:32]};
               lo_in    = {ua_ff[31:0], 32'd0};
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring division: one quotient bit shifts in per cycle
            alu_req.x   = {1'b0, rem_sh};
            alu_req.y   = {1'b0, ub_ff};
            alu_req.sub = 1'b1;
            hi_in       = quot_bit ? alu_sum[63:0] : rem_sh;
            lo_in       = {lo_ff[62:0], quot_bit};
            iter_in     = iter_ff - 6'd1;
            if (iter_ff == 6'd0) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            alu_req.y   = {1'b0, mag_m};
            alu_req.sub = 1'b1;
            st_we       = 1'b1;
            st_wdata    = fix_r;
            top_in      = fix_r;
            count_in    = count_m1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            // hold until the output register is free, then load the beat
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sticky_ff;
               rsp_done_in   = (cmd_ff == CMD_FINISH);
               rsp_top_in    = (count_ff != '0) ? top_ff : 64'd0;
               rsp_answer_in = (cmd_ff == CMD_FINISH) && (sticky_ff < ST_OVERFLOW) &&
                               (count_ff != '0) && (top_ff != 64'd0);
               if (cmd_ff == CMD_FINISH) begin
                  count_in  = '0;
                  sticky_in = ST_OK;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sticky_ff    <= ST_OK;
         var_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
         if (csr_chan.valid && csr_chan.ready) begin
            var_count_ff <= csr_chan.data;
         end
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_chan.cmd;
         op_ff  <= req_chan.opcode;
         imm_ff <= req_chan.immediate;
         idx_ff <= req_chan.var_index;
      end
      top_ff        <= top_in;
      ua_ff         <= ua_in;
      ub_ff         <= ub_in;
      hi_ff         <= hi_in;
      lo_ff         <= lo_in;
      neg_ff        <= neg_in;
      ovf_ff        <= ovf_in;
      rsp_status_ff <= rsp_status_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_top_ff    <= rsp_top_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.done_res  = rsp_done_ff;
   assign rsp_chan.answer    = rsp_answer_ff;
   assign rsp_chan.top_value = rsp_top_ff;

   // stack count never passes the stack depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= StackFull)
      else $error("stack count beyond depth");

   // an accepted beat drops ready on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("ready high right after accept");

   // a finish result leaves the stack empty and the status clear
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_free && cmd_ff == CMD_FINISH)
      |=> (count_ff == '0 && sticky_ff == ST_OK))
      else $error("finish did not clear stack state");

endmodule
`default_nettype wire

@@ test/stack_expression_evaluator_test.sv @@
// Testbench for the stack expression evaluator: directed table, then random programs.
// Depends on see_pkg, see_req_if, see_rsp_if, see_csr_if and the evaluator RTL.
`default_nettype none
module stack_expression_evaluator_test;
   import see_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   see_req_if req_chan ();
   see_rsp_if rsp_chan ();
   see_csr_if csr_chan ();

   stack_expression_evaluator dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   // one expected response beat
   typedef struct packed {
      status_type  status;
      logic        done_res;
      logic        answer;
      logic [63:0] top_value;
   } verdict_t;

   // one directed row; check_fixed marks a hand-typed expectation
   typedef struct {
      cmd_type     cmd;
      opcode_type  opcode;
      logic [63:0] immediate;
      index_type   var_index;
      logic        check_fixed;
      verdict_t    fixed;
   } row_t;

   // predictor state
   logic [63:0]   pred_stack [256];
   int unsigned   pred_depth;
   logic [63:0]   pred_vars [256];
   bit            pred_written [256];
   status_type    pred_sticky;
   count_cfg_type pred_var_count;

   verdict_t expected_beats[$];
   int       error_count = 0;
   int       sent_count  = 0;
   bit       rsp_calm    = 1'b0;
   bit       req_calm    = 1'b0;

   function automatic logic [63:0] mag(logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   function automatic logic [63:0] saturate(logic [63:0] m, bit neg, bit over);
      if (over || m > (neg ? Q_MIN : Q_MAX)) return neg ? Q_MIN : Q_MAX;
      return neg ? -m : m;
   endfunction

   function automatic logic [63:0] fixed_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = mag(a) * mag(b);
      return saturate(prod[95:32], a[63] ^ b[63], prod[127:96] != 0);
   endfunction

   function automatic logic [63:0] fixed_div(logic [63:0] a, logic [63:0] b);
      logic [127:0] quo;
      quo = {32'd0, mag(a), 32'd0} / {64'd0, mag(b)};
      return saturate(quo[63:0], a[63] ^ b[63], quo[127:64] != 0);
   endfunction

   function automatic logic [63:0] flag(bit c);
      return c ? Q_ONE : 64'd0;
   endfunction

   function automatic void run_opcode(opcode_type op, logic [63:0] imm, index_type idx);
      logic [63:0] a, b, r;
      if (op == OP_HALT) begin pred_sticky = ST_HALTED; return; end
      if (op == OP_PUSH || op == OP_LOAD) begin
         if (op == OP_LOAD) begin
            if (idx >= pred_var_count) begin pred_sticky = ST_BAD_INDEX; return; end
            imm = pred_vars[idx];
         end
         if (pred_depth >= 256) begin pred_sticky = ST_OVERFLOW; return; end
         pred_stack[pred_depth] = imm;
         pred_depth++;
         return;
      end
      if (op == OP_NOT) begin
         if (pred_depth < 1) begin pred_sticky = ST_UNDERFLOW; return; end
         pred_stack[pred_depth-1] = flag(pred_stack[pred_depth-1] == 0);
         return;
      end
      if (!(op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_LT, OP_AND, OP_OR}))
      begin
         pred_sticky = ST_BAD_OP;
         return;
      end
      if (pred_depth < 2) begin pred_sticky = ST_UNDERFLOW; return; end
      a = pred_stack[pred_depth-2];
      b = pred_stack[pred_depth-1];
      case (op)
         OP_ADD: begin
            r = a + b;
            if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? Q_MIN : Q_MAX;
         end
         OP_SUB: begin
            r = a - b;
            if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? Q_MIN : Q_MAX;
         end
         OP_MUL: r = fixed_mul(a, b);
         OP_DIV: begin
            if (b == 0) begin pred_sticky = ST_DIV_ZERO; return; end
            r = fixed_div(a, b);
         end
         OP_EQ:  r = flag(a == b);
         OP_GT:  r = flag($signed(b) < $signed(a));
         OP_LT:  r = flag($signed(a) < $signed(b));
         OP_AND: r = flag(a != 0 && b != 0);
         default: r = flag(a != 0 || b != 0);
      endcase
      pred_depth--;
      pred_stack[pred_depth-1] = r;
   endfunction

   // advance the predictor by one beat and return what the block must answer
   function automatic verdict_t evaluate(cmd_type cmd, opcode_type op, logic [63:0] imm,
                                         index_type idx);
      verdict_t v;
      if (cmd == CMD_WRITE) begin
         pred_vars[idx] = imm;
         pred_written[idx] = 1'b1;
      end else if (cmd == CMD_EXEC && pred_sticky == ST_OK) begin
         run_opcode(op, imm, idx);
      end
      v.status    = pred_sticky;
      v.top_value = pred_depth > 0 ? pred_stack[pred_depth-1] : 64'd0;
      v.done_res  = cmd == CMD_FINISH;
      v.answer    = 1'b0;
      if (cmd == CMD_FINISH) begin
         v.answer = pred_sticky < ST_OVERFLOW && pred_depth > 0 && v.top_value != 0;
         pred_depth  = 0;
         pred_sticky = ST_OK;
      end
      return v;
   endfunction

   // drive inputs to known values from time zero
   initial begin
      req_chan.valid = 1'b0;
      req_chan.cmd = CMD_WRITE;
      req_chan.opcode = OP_HALT;
      req_chan.immediate = '0;
      req_chan.var_index = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      rsp_chan.ready = 1'b0;
   end

   // sink side: not ready about 37 percent of the time unless in a calm stretch
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= rsp_calm || ($urandom_range(99) >= 37);
   end

   // check every accepted response beat against the oldest expectation
   always @(posedge clock) begin
      verdict_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected response beat status=%0d top=%h", $time,
                     rsp_chan.status, rsp_chan.top_value);
            error_count++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.done_res !== want.done_res) begin
               $display("%0t: done_res expected %0b actual %0b", $time, want.done_res,
                        rsp_chan.done_res);
               error_count++;
            end
            if (rsp_chan.answer !== want.answer) begin
               $display("%0t: answer expected %0b actual %0b", $time, want.answer,
                        rsp_chan.answer);
               error_count++;
            end
            if (rsp_chan.top_value !== want.top_value) begin
               $display("%0t: top_value expected %h actual %h", $time, want.top_value,
                        rsp_chan.top_value);
               error_count++;
            end
         end
      end
   end

   // send one request beat; hold valid across back-to-back beats
   task automatic send_beat(cmd_type cmd, opcode_type op, logic [63:0] imm, index_type idx,
                            bit check_fixed, verdict_t fixed);
      verdict_t v;
      while (!req_calm && $urandom_range(99) < 37) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.cmd       <= cmd;
      req_chan.opcode    <= op;
      req_chan.immediate <= imm;
      req_chan.var_index <= idx;
      v = evaluate(cmd, op, imm, idx);
      if (check_fixed && v != fixed) begin
         $display("%0t: table row disagrees with predictor: expected %0d/%h actual %0d/%h",
                  $time, fixed.status, fixed.top_value, v.status, v.top_value);
         error_count++;
      end
      expected_beats.push_back(v);
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // write the variable count while idle
   task automatic write_var_count(count_cfg_type n);
      drain();
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= n;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      pred_var_count = n;
      @(posedge clock);
   endtask

   task automatic plain(cmd_type cmd, opcode_type op, logic [63:0] imm, index_type idx);
      verdict_t none;
      none = '{default: 0};
      send_beat(cmd, op, imm, idx, 1'b0, none);
   endtask

   function automatic logic [63:0] random_q();
      case ($urandom_range(5))
         0: return {$urandom, $urandom};
         1: return {{32{1'b0}}, $urandom} << $urandom_range(32);
         2: return $urandom_range(1) ? Q_MAX : Q_MIN;
         3: return flag($urandom_range(1));
         4: return -({32'd0, $urandom} << $urandom_range(32));
         default: return {$urandom_range(7) == 0 ? 32'd0 : 32'(int'($urandom_range(9)) - 4),
                          $urandom};
      endcase
   endfunction

   // a random slot for a load: a written slot if one is found, else slot 0
   function automatic index_type written_slot();
      index_type i;
      repeat (20) begin
         i = $urandom_range(255);
         if (pred_written[i]) return i;
      end
      return 8'd0;
   endfunction

   localparam opcode_type BINARY_OPS [9] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT,
                                             OP_LT, OP_AND, OP_OR};

   // a well-formed expression with random content, ending in a finish
   task automatic random_program();
      int n, live;
      n = $urandom_range(1, 10);
      live = 0;
      for (int k = 0; k < n; k++) begin
         if (live < 2 || $urandom_range(2) == 0) begin
            if ($urandom_range(1) && pred_var_count != 0 && pred_written[0])
               plain(CMD_EXEC, OP_LOAD, random_q(), written_slot());
            else
               plain(CMD_EXEC, OP_PUSH, random_q(), 8'($urandom));
            live++;
         end else if ($urandom_range(5) == 0) begin
            plain(CMD_EXEC, OP_NOT, random_q(), 8'($urandom));
         end else begin
            plain(CMD_EXEC, BINARY_OPS[$urandom_range(8)], random_q(), 8'($urandom));
            live--;
         end
      end
      plain(CMD_FINISH, 8'($urandom), random_q(), 8'($urandom));
   endtask

   // noise: raw beats, loads only of written or out-of-range slots
   task automatic random_noise();
      cmd_type    c;
      opcode_type op;
      index_type  idx;
      c   = 2'($urandom);
      op  = $urandom_range(1) ? 8'($urandom) : BINARY_OPS[$urandom_range(8)];
      idx = 8'($urandom);
      if (c == CMD_EXEC && op == OP_LOAD && idx < pred_var_count && !pred_written[idx])
         idx = written_slot();
      if (c == CMD_EXEC && op == OP_LOAD && idx < pred_var_count && !pred_written[idx])
         op = OP_PUSH;
      plain(c, op, random_q(), idx);
   endtask

   function automatic verdict_t fx(status_type s, logic d, logic a, logic [63:0] t);
      verdict_t v;
      v.status = s; v.done_res = d; v.answer = a; v.top_value = t;
      return v;
   endfunction

   row_t directed [$];

   initial begin
      count_cfg_type settings [4];
      pred_depth = 0;
      pred_sticky = ST_OK;
      pred_var_count = 0;
      foreach (pred_written[i]) pred_written[i] = 1'b0;
      settings = '{9'd256, 9'd1, 9'd17, 9'd0};

      // directed table: fixed expectations where obvious, predictor elsewhere
      directed = '{
         '{CMD_FINISH, OP_HALT, 64'd0,   8'd0,   1, fx(ST_OK, 1, 0, 0)},
         '{CMD_EXEC,   OP_ADD,  64'd0,   8'd0,   1, fx(ST_UNDERFLOW, 0, 0, 0)},
         '{CMD_EXEC,   OP_PUSH, Q_MAX,   8'd0,   1, fx(ST_UNDERFLOW, 0, 0, 0)},
         '{CMD_FINISH, OP_HALT, 64'd0,   8'd0,   1, fx(ST_UNDERFLOW, 1, 0, 0)},
         '{CMD_WRITE,  OP_HALT, Q_MIN,   8'd255, 1, fx(ST_OK, 0, 0, 0)},
         '{CMD_WRITE,  OP_HALT, Q_ONE,   8'd0,   1, fx(ST_OK, 0, 0, 0)},
         '{CMD_EXEC,   OP_LOAD, 64'd0,   8'd255, 0, fx(0, 0, 0, 0)},
         '{CMD_EXEC,   OP_LOAD, 64'd0,   8'd0,   0, fx(0, 0, 0, 0)},
         '{CMD_EXEC,   OP_PUSH, Q_MAX,   8'd0,   0, fx(0, 0, 0, 0)},
         '{CMD_EXEC,   OP_ADD,  64'd0,   8'd0,   0, fx(0, 0, 0, 0)},
         '{CMD_EXEC,   OP_PUSH, Q_MIN,   8'd0,   0, fx(0, 0, 0, 0)},
         '{CMD_EXEC,   OP_MUL,  64'd0,   8'd0,   0, fx(0, 0, 0, 0)},
         '{CMD_EXEC,   OP_PUSH, -64'sd1, 8'd0,   0, fx(0, 0, 0, 0)},
         '{CMD_EXEC,   OP_DIV,  64'd0,   8'd0,   0, fx(0, 0, 0, 0)},
         '{CMD_EXEC,   OP_PUSH, 64'd0,   8'd0,   0, fx(0, 0, 0, 0)},
         '{CMD_EXEC,   OP_DIV,  64'd0,   8'd0,   0, fx(0, 0, 0, 0)},
         '{CMD_EXEC,   OP_NOT,  64'd0,   8'd0,   0, fx(0, 0, 0, 0)},
         '{CMD_FINISH, OP_HALT, 64'd0,   8'd0,   0, fx(0, 0, 0, 0)},
         '{CMD_EXEC,   OP_HALT, 64'd0,   8'd0,   1, fx(ST_HALTED, 0, 0, 0)},
         '{CMD_EXEC,   OP_PUSH, Q_ONE,   8'd0,   1, fx(ST_HALTED, 0, 0, 0)},
         '{2'd3,       OP_NOT,  64'd5,   8'd3,   1, fx(ST_HALTED, 0, 0, 0)},
         '{CMD_FINISH, OP_HALT, 64'd0,   8'd0,   1, fx(ST_HALTED, 1, 0, 0)},
         '{CMD_EXEC,   8'hFF,   64'd0,   8'd0,   1, fx(ST_BAD_OP, 0, 0, 0)},
         '{CMD_FINISH, OP_HALT, 64'd0,   8'd0,   1, fx(ST_BAD_OP, 1, 0, 0)}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_var_count(9'd256);
      foreach (directed[i])
         send_beat(directed[i].cmd, directed[i].opcode, directed[i].immediate,
                   directed[i].var_index, directed[i].check_fixed, directed[i].fixed);
      // overflow: fill the stack then push once more
      for (int k = 0; k < 257; k++) plain(CMD_EXEC, OP_PUSH, random_q(), 8'($urandom));
      plain(CMD_FINISH, OP_HALT, 64'd0, 8'd0);

      // fill every slot so that loads below the count stay legal
      for (int k = 0; k < 256; k++) plain(CMD_WRITE, OP_HALT, random_q(), 8'(k));

      // random phases over several variable counts, one calm stretch
      for (int phase = 0; phase < 4; phase++) begin
         write_var_count(settings[phase]);
         req_calm = phase == 1;
         rsp_calm = phase == 1;
         while (sent_count < 600 + phase * 250) begin
            if ($urandom_range(4) == 0) random_noise();
            else random_program();
         end
         // hold off until every response is back
         req_chan.valid <= 1'b0;
         while (expected_beats.size() != 0) @(posedge clock);
      end
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      drain();

      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #8000000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire
